>>> rtl/waveform_peak_pyramid_unit_macros.svh
// Assertion macros for the waveform peak pyramid unit.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef WAVEFORM_PEAK_PYRAMID_UNIT_MACROS_SVH
`define WAVEFORM_PEAK_PYRAMID_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WPP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define WPP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/wpp_pkg.sv
// Shared types and constants of the waveform peak pyramid unit.
// No dependencies; used by the top level, wpp_ctrl and wpp_dp.
`default_nettype none

package wpp_pkg;

    localparam int LEVELS = 4;
    // Block sizes 16, 64, 256 and 1024 points as shift amounts.
    localparam int LVL_SHIFT [LEVELS] = '{4, 6, 8, 10};
    localparam int POINT_FIELD_W = 17;
    localparam logic [POINT_FIELD_W-1:0] SRC_RESET = 17'h10000;

    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_SAMPLE   = 2'd1,
        CMD_QUERY    = 2'd2,
        CMD_OVERVIEW = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [7:0] amp;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_peak;

    typedef struct packed {
        logic [3:0]               pad;
        logic [7:0]               column;
        logic [POINT_FIELD_W-1:0] range_end;
        logic [POINT_FIELD_W-1:0] range_begin;
        logic [7:0]               blue;
        logic [7:0]               green;
        logic [7:0]               red;
        logic [7:0]               amplitude;
        logic [1:0]               command;
    } t_in_item;

    typedef struct packed {
        logic [5:0] pad;
        logic       scan_done;
        logic [7:0] peak_blue;
        logic [7:0] peak_green;
        logic [7:0] peak_red;
        logic [7:0] peak_amplitude;
        logic       status;
    } t_out_item;

    typedef struct packed {
        logic latch;
        logic start_ok;
        logic reject;
        logic div_start;
        logic clr_step;
        logic smp_wr;
        logic q_init;
        logic q_rd;
        logic q_cmp;
        logic ov_rd;
        logic ov_load;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic ok;
        logic clr_last;
        logic div_done;
        logic q_last;
        logic out_free;
        logic scanning;
        logic index_valid;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/waveform_peak_pyramid_unit.sv
// Top level of the waveform peak pyramid unit: stream ports, controller, datapath.
// Depends on wpp_pkg, wpp_ctrl, wpp_dp and the assertion macro header.
`default_nettype none

`include "waveform_peak_pyramid_unit_macros.svh"

// One item is handled at a time and gives exactly one result. After reset
// the overview memory is swept to zero before the first item is taken. A
// valid start sweeps it again. A sample runs the bit-serial column divider,
// one quotient bit a cycle. A range query reads the chosen level one bucket
// at a time, a read and then a compare per bucket, at most 64 buckets at the
// default MAX_POINTS. A new item is taken while the previous result still
// waits in the output register.
module waveform_peak_pyramid_unit #(
    parameter int MAX_POINTS       = 65536,
    parameter int OVERVIEW_COLUMNS = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command, amplitude, red, green, blue, range_begin, range_end, column
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status, peak_amplitude, peak_red, peak_green, peak_blue, scan_done
    output logic [39:0]      m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [16:0] i_cfg_data
);

    wpp_pkg::t_dp_cmd   dp_cmd;
    wpp_pkg::t_dp_stat  dp_stat;
    wpp_pkg::t_out_item out_item;

    wpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    wpp_dp #(
        .MAX_POINTS       (MAX_POINTS),
        .OVERVIEW_COLUMNS (OVERVIEW_COLUMNS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_item      (wpp_pkg::t_in_item'(s_axis_tdata)),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (out_item)
    );

    assign m_axis_tdata = out_item;
    assign o_cfg_ready  = 1'b1;

    `WPP_ASSERT_IMP(a_no_overwrite, dp_cmd.out_load, dp_stat.out_free, "result overwritten")
    `WPP_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second transfer taken")
    `WPP_ASSERT_IMP(a_scan_excl, 1'b1, !(dp_stat.scanning && dp_stat.index_valid), "scan and index both set")

endmodule

`default_nettype wire

>>> rtl/wpp_div.sv
// Iterative column divider: floor(num * COLUMNS / den), one quotient bit a cycle.
// Standalone; instantiated by wpp_dp.
`default_nettype none

module wpp_div #(
    parameter int PW      = 17,
    parameter int COLUMNS = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [PW-1:0] i_num,
    input  wire logic [PW-1:0] i_den,
    output logic               o_done,
    output logic [((COLUMNS > 1) ? $clog2(COLUMNS) : 1)-1:0] o_quot
);

    localparam int CW = $clog2(COLUMNS + 1);
    localparam int QW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int NW = $clog2(QW + 1);

    logic [PW+CW-1:0] prod;
    logic [PW:0]      trial;
    logic             qbit;
    logic [PW-1:0]    r_rem;
    logic [QW-1:0]    r_lo;
    logic [QW-1:0]    r_q;
    logic [NW-1:0]    r_cnt;
    logic             r_busy;

    // The quotient is below COLUMNS, so the top part of the product is
    // already below den and the division needs only QW steps.
    assign prod  = (PW+CW)'(i_num) * (PW+CW)'(COLUMNS);
    assign trial = {r_rem, r_lo[QW-1]};
    assign qbit  = (trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= NW'(QW);
            r_rem  <= PW'(prod >> QW);
            r_lo   <= QW'(prod);
            r_q    <= '0;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - NW'(1);
                r_rem <= qbit ? PW'(trial - {1'b0, i_den}) : PW'(trial);
                r_lo  <= QW'({r_lo, 1'b0});
                r_q   <= QW'({r_q, qbit});
            end
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_q;

endmodule

`default_nettype wire

>>> rtl/wpp_dp.sv
// Datapath of the waveform peak pyramid: registers, overview and level memories.
// Depends on wpp_pkg and wpp_div.
`default_nettype none

module wpp_dp #(
    parameter int MAX_POINTS       = 65536,
    parameter int OVERVIEW_COLUMNS = 256
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire wpp_pkg::t_dp_cmd    i_cmd,
    output wpp_pkg::t_dp_stat        o_stat,
    input  wire wpp_pkg::t_in_item   i_item,
    input  wire logic                i_cfg_valid,
    input  wire logic [wpp_pkg::POINT_FIELD_W-1:0] i_cfg_data,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output wpp_pkg::t_out_item       o_m_tdata
);

    localparam int PW   = $clog2(MAX_POINTS + 1);
    localparam int CMPW = (PW > wpp_pkg::POINT_FIELD_W) ? PW : wpp_pkg::POINT_FIELD_W;
    localparam int OVW  = (OVERVIEW_COLUMNS > 1) ? $clog2(OVERVIEW_COLUMNS) : 1;
    localparam int FW   = wpp_pkg::POINT_FIELD_W;

    logic [FW-1:0]       r_src;
    wpp_pkg::t_in_item   r_item;
    logic [PW-1:0]       r_active;
    logic [PW-1:0]       r_pos;
    logic                r_scanning;
    logic                r_valid;
    logic [OVW-1:0]      r_clr;
    wpp_pkg::t_peak      r_res;
    logic                r_rej;
    logic [1:0]          r_qlvl;
    logic [CMPW-1:0]     r_e;
    logic [CMPW-1:0]     r_last;
    logic                r_ovalid;
    wpp_pkg::t_out_item  r_out;

    wpp_pkg::t_peak      sample;
    wpp_pkg::t_peak      lv_rd [wpp_pkg::LEVELS];
    logic                div_done;
    logic [OVW-1:0]      div_quot;
    logic                ok;
    logic [CMPW-1:0]     beg;
    logic [CMPW-1:0]     en;
    logic [CMPW-1:0]     act;
    logic [FW-1:0]       wid;
    logic [1:0]          q_lvl;
    logic [3:0]          q_sh;
    logic [CMPW-1:0]     q_first;
    logic [CMPW-1:0]     q_lastraw;
    logic [CMPW-1:0]     q_cntm1;
    logic                q_last;
    logic                clr_last;

    assign sample = '{amp: r_item.amplitude, red: r_item.red,
                      green: r_item.green, blue: r_item.blue};

    wpp_div #(
        .PW      (PW),
        .COLUMNS (OVERVIEW_COLUMNS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_pos),
        .i_den   (r_active),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Command acceptance checks on the latched item.
    assign beg = CMPW'(r_item.range_begin);
    assign en  = CMPW'(r_item.range_end);
    assign act = CMPW'(r_active);

    always_comb begin
        case (wpp_pkg::t_cmd'(r_item.command))
            wpp_pkg::CMD_START:
                ok = (r_src != '0) && (CMPW'(r_src) <= CMPW'(MAX_POINTS));
            wpp_pkg::CMD_SAMPLE:
                ok = r_scanning && (r_pos < r_active);
            wpp_pkg::CMD_QUERY:
                ok = r_valid && (beg < en) && (en <= act);
            wpp_pkg::CMD_OVERVIEW:
                ok = (32'(r_item.column) < 32'(OVERVIEW_COLUMNS));
            default:
                ok = 1'b0;
        endcase
    end

    // Coarsest level whose block fits the range width.
    assign wid = r_item.range_end - r_item.range_begin;

    always_comb begin
        q_lvl = 2'd0;
        for (int k = 1; k < wpp_pkg::LEVELS; k++) begin
            if (wid >= FW'(1 << wpp_pkg::LVL_SHIFT[k])) begin
                q_lvl = 2'(k);
            end
        end
    end

    assign q_sh      = 4'(wpp_pkg::LVL_SHIFT[q_lvl]);
    assign q_first   = beg >> q_sh;
    assign q_lastraw = (en - CMPW'(1)) >> q_sh;
    assign q_cntm1   = (act - CMPW'(1)) >> q_sh;
    assign q_last    = (r_e == r_last);
    assign clr_last  = (r_clr == OVW'(OVERVIEW_COLUMNS - 1));

    // Level memories. The first point of a bucket sees the bucket as empty,
    // so a start needs no clearing pass over these stores.
    for (genvar k = 0; k < wpp_pkg::LEVELS; k++) begin : g_lvl
        localparam int SH    = wpp_pkg::LVL_SHIFT[k];
        localparam int DEPTH = (MAX_POINTS + (1 << SH) - 1) >> SH;
        localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

        wpp_pkg::t_peak mem [DEPTH];
        wpp_pkg::t_peak r_rd;
        wpp_pkg::t_peak old;
        logic [AW-1:0]  addr;
        logic [AW-1:0]  waddr;
        logic           fresh;

        assign waddr = AW'(r_pos >> SH);
        assign addr  = i_cmd.q_rd ? AW'(r_e) : waddr;
        assign fresh = (r_pos[SH-1:0] == '0);
        assign old   = fresh ? '0 : r_rd;

        always_ff @(posedge i_clk) begin
            if (i_cmd.smp_wr) begin
                mem[waddr] <= (sample.amp > old.amp) ? sample : old;
            end
            r_rd <= mem[addr];
        end

        assign lv_rd[k] = r_rd;
    end

    // Overview memory, cleared by a sweep after reset and after each accepted start.
    wpp_pkg::t_peak ov_mem [OVERVIEW_COLUMNS];
    wpp_pkg::t_peak r_ov_rd;
    logic [OVW-1:0] ov_addr;
    logic [OVW-1:0] ov_waddr;

    assign ov_addr  = i_cmd.ov_rd ? OVW'(r_item.column) : div_quot;
    assign ov_waddr = i_cmd.clr_step ? r_clr : div_quot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            ov_mem[ov_waddr] <= '0;
        end else if (i_cmd.smp_wr) begin
            ov_mem[ov_waddr] <= (sample.amp > r_ov_rd.amp) ? sample : r_ov_rd;
        end
        r_ov_rd <= ov_mem[ov_addr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src      <= wpp_pkg::SRC_RESET;
            r_active   <= '0;
            r_pos      <= '0;
            r_scanning <= 1'b0;
            r_valid    <= 1'b0;
            r_clr      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_src <= i_cfg_data;
            end
            if (i_cmd.start_ok) begin
                r_active   <= PW'(r_src);
                r_pos      <= '0;
                r_scanning <= 1'b1;
                r_valid    <= 1'b0;
                r_clr      <= '0;
            end
            if (i_cmd.reject && (r_item.command == wpp_pkg::CMD_START)) begin
                r_scanning <= 1'b0;
                r_valid    <= 1'b0;
            end
            if (i_cmd.clr_step) begin
                r_clr <= clr_last ? '0 : r_clr + OVW'(1);
            end
            if (i_cmd.smp_wr) begin
                r_pos <= r_pos + PW'(1);
                if (r_pos + PW'(1) == r_active) begin
                    r_scanning <= 1'b0;
                    r_valid    <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.start_ok || i_cmd.smp_wr || i_cmd.q_init) begin
            r_res <= '0;
            r_rej <= 1'b0;
        end
        if (i_cmd.reject) begin
            r_res <= '0;
            r_rej <= 1'b1;
        end
        if (i_cmd.q_init) begin
            r_qlvl <= q_lvl;
            r_e    <= q_first;
            r_last <= (q_lastraw > q_cntm1) ? q_cntm1 : q_lastraw;
        end
        if (i_cmd.q_cmp) begin
            if (lv_rd[r_qlvl].amp > r_res.amp) begin
                r_res <= lv_rd[r_qlvl];
            end
            if (!q_last) begin
                r_e <= r_e + CMPW'(1);
            end
        end
        if (i_cmd.ov_load) begin
            r_res <= r_ov_rd;
            r_rej <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out <= '{pad: '0, scan_done: r_valid, peak_blue: r_res.blue,
                       peak_green: r_res.green, peak_red: r_res.red,
                       peak_amplitude: r_res.amp, status: r_rej};
        end
    end

    assign o_stat = '{cmd: wpp_pkg::t_cmd'(r_item.command), ok: ok,
                      clr_last: clr_last, div_done: div_done, q_last: q_last,
                      out_free: (!r_ovalid || i_m_tready),
                      scanning: r_scanning, index_valid: r_valid};

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_out;

endmodule

`default_nettype wire

>>> rtl/wpp_ctrl.sv
// Controller state machine of the waveform peak pyramid.
// Depends on wpp_pkg; drives wpp_dp through command and status structs.
`default_nettype none

module wpp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output wpp_pkg::t_dp_cmd       o_cmd,
    input  wire wpp_pkg::t_dp_stat i_stat
);

    typedef enum logic [11:0] {
        ST_IDLE = 12'b000000000001,
        ST_RCLR = 12'b000000000010,
        ST_DEC  = 12'b000000000100,
        ST_CLR  = 12'b000000001000,
        ST_DIV  = 12'b000000010000,
        ST_SRD  = 12'b000000100000,
        ST_SWR  = 12'b000001000000,
        ST_QRD  = 12'b000010000000,
        ST_QCMP = 12'b000100000000,
        ST_ORD  = 12'b001000000000,
        ST_OLD  = 12'b010000000000,
        ST_RESP = 12'b100000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_DEC;
                end
            end
            ST_RCLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DEC: begin
                if (!i_stat.ok) begin
                    o_cmd.reject = 1'b1;
                    n_state      = ST_RESP;
                end else begin
                    case (i_stat.cmd)
                        wpp_pkg::CMD_START: begin
                            o_cmd.start_ok = 1'b1;
                            n_state        = ST_CLR;
                        end
                        wpp_pkg::CMD_SAMPLE: begin
                            o_cmd.div_start = 1'b1;
                            n_state         = ST_DIV;
                        end
                        wpp_pkg::CMD_QUERY: begin
                            o_cmd.q_init = 1'b1;
                            n_state      = ST_QRD;
                        end
                        default: begin
                            n_state = ST_ORD;
                        end
                    endcase
                end
            end
            ST_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_RESP;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_SRD;
                end
            end
            ST_SRD: begin
                n_state = ST_SWR;
            end
            ST_SWR: begin
                o_cmd.smp_wr = 1'b1;
                n_state      = ST_RESP;
            end
            ST_QRD: begin
                o_cmd.q_rd = 1'b1;
                n_state    = ST_QCMP;
            end
            ST_QCMP: begin
                o_cmd.q_cmp = 1'b1;
                n_state     = i_stat.q_last ? ST_RESP : ST_QRD;
            end
            ST_ORD: begin
                o_cmd.ov_rd = 1'b1;
                n_state     = ST_OLD;
            end
            ST_OLD: begin
                o_cmd.ov_load = 1'b1;
                n_state       = ST_RESP;
            end
            ST_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RCLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire
